FILE: sv/fdtd_pkg.sv
// fdtd_pkg: shared constants, register codes and pipeline control type
// for the FDTD wave cell update. No dependencies.
package fdtd_pkg;

    localparam int PRESSURE_WIDTH_DEF = 32;

    localparam int CMD_W      = 4;
    localparam int COURANT_W  = 17;  // unsigned Q1.16
    localparam int INV_WALL_W = 18;  // unsigned Q2.16
    localparam int GAIN_W     = 17;  // unsigned Q1.16

    localparam logic [INV_WALL_W-1:0] INV_WALL_RST = INV_WALL_W'(57321);
    localparam logic [GAIN_W-1:0]     GAIN_RST     = GAIN_W'(64881);

    // position classes
    localparam logic [CMD_W-1:0] CMD_INTERIOR  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_LEFT      = 4'd1;
    localparam logic [CMD_W-1:0] CMD_RIGHT     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_TOP       = 4'd3;
    localparam logic [CMD_W-1:0] CMD_BOTTOM    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_TOP_LEFT  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_TOP_RIGHT = 4'd6;
    localparam logic [CMD_W-1:0] CMD_BOT_LEFT  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_BOT_RIGHT = 4'd8;

    // register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_INV_WALL = 1'b0;
    localparam logic REG_GAIN     = 1'b1;

    // arithmetic layout
    localparam int DEN_FRAC    = 32;  // extra fraction bits of num/den
    localparam int ROUND_SHIFT = 48;  // interior: 32 + gain fraction
    localparam int DEN_W       = DEN_FRAC + 5;  // 2^32 + k*C/Ew
    localparam int DIV_W       = DEN_W + 1;     // doubled divisor
    localparam int NUM_XTRA    = 38;  // numerator width over pressure width
    localparam int QUO_XTRA    = 6;   // quotient width over pressure width
    localparam int RES_XTRA    = 7;   // unsaturated result width over it
    localparam int DIV_STEPS   = 4;   // quotient bits per divider stage

    typedef struct packed {
        logic valid;
        logic is_int;  // interior: result taken from gain path
        logic neg;     // boundary: negative dividend
    } t_pipe_ctl;

endpackage

FILE: sv/fdtd_if.sv
// fdtd_in_if / fdtd_out_if: request channels of the cell update.
// Depends on fdtd_pkg.
interface fdtd_in_if import fdtd_pkg::*; #(
    parameter int PW = PRESSURE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [PW-1:0]    cur_pressure;
    logic signed [PW-1:0]    prev_pressure;
    logic signed [PW-1:0]    west_pressure;
    logic signed [PW-1:0]    east_pressure;
    logic signed [PW-1:0]    north_pressure;
    logic signed [PW-1:0]    south_pressure;
    logic [COURANT_W-1:0]    courant;

    modport source (output valid, cmd, cur_pressure, prev_pressure, west_pressure,
                    east_pressure, north_pressure, south_pressure, courant,
                    input ready);
    modport sink (input valid, cmd, cur_pressure, prev_pressure, west_pressure,
                  east_pressure, north_pressure, south_pressure, courant,
                  output ready);
endinterface

interface fdtd_out_if import fdtd_pkg::*; #(
    parameter int PW = PRESSURE_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [PW-1:0] next_pressure;
    logic                 saturated;

    modport source (output valid, next_pressure, saturated, input ready);
    modport sink (input valid, next_pressure, saturated, output ready);
endinterface

FILE: sv/fdtd_stencil.sv
// fdtd_stencil: six-stage front end. Laplacian, Courant/wall products,
// numerator and divisor for boundaries, gain and rounding for interior.
// Depends on fdtd_pkg and fdtd_if.
module fdtd_stencil import fdtd_pkg::*; #(
    parameter int PW = PRESSURE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    fdtd_in_if.sink                 i_cell,
    input  logic [INV_WALL_W-1:0]   i_inv_wall,
    input  logic [GAIN_W-1:0]       i_gain,
    input  logic                    i_ready,
    output t_pipe_ctl               o_ctl,
    output logic [DIV_W-1:0]        o_rem,
    output logic [PW+QUO_XTRA-1:0]  o_lo,
    output logic [DIV_W-1:0]        o_d2,
    output logic signed [PW+RES_XTRA-1:0] o_ires
);
    localparam int CW   = COURANT_W;
    localparam int LW   = PW + 4;
    localparam int BW   = PW + 2;
    localparam int LCW  = LW + CW + 1;
    localparam int PCW  = PW + CW + 1;
    localparam int CIW  = CW + INV_WALL_W;
    localparam int LSW  = CIW + 1;
    localparam int NW   = PW + NUM_XTRA;
    localparam int XW   = NW + 1;
    localparam int QW   = PW + QUO_XTRA;
    localparam int RW   = PW + RES_XTRA;
    localparam int HW   = NW - 32;
    localparam int PHW  = HW + GAIN_W + 1;
    localparam int PLOW = 32 + GAIN_W;
    localparam int SW   = PW + 56;
    localparam int LCCF = LCW + CW + 1;
    localparam int PLF  = PCW + INV_WALL_W + 1;

    // ---- stage 1 logic: laplacian and leapfrog base
    logic signed [LW-1:0] w_c, w_w, w_e, w_n, w_s, w_lap;
    logic                 w_int, w_k2;
    logic signed [BW-1:0] w_base;

    assign w_c = LW'(i_cell.cur_pressure);
    assign w_w = LW'(i_cell.west_pressure);
    assign w_e = LW'(i_cell.east_pressure);
    assign w_n = LW'(i_cell.north_pressure);
    assign w_s = LW'(i_cell.south_pressure);
    assign w_base = (BW'(i_cell.cur_pressure) <<< 1) - BW'(i_cell.prev_pressure);
    assign w_int = (i_cell.cmd == CMD_INTERIOR) || (i_cell.cmd > CMD_BOT_RIGHT);
    assign w_k2  = !w_int && (i_cell.cmd >= CMD_TOP_LEFT);

    always_comb begin
        case (i_cell.cmd)
            CMD_LEFT:      w_lap = (w_e <<< 1) + w_n + w_s - (w_c <<< 2);
            CMD_RIGHT:     w_lap = (w_w <<< 1) + w_n + w_s - (w_c <<< 2);
            CMD_TOP:       w_lap = (w_s <<< 1) + w_w + w_e - (w_c <<< 2);
            CMD_BOTTOM:    w_lap = (w_n <<< 1) + w_w + w_e - (w_c <<< 2);
            CMD_TOP_LEFT:  w_lap = (w_e <<< 1) + (w_s <<< 1) - (w_c <<< 2);
            CMD_TOP_RIGHT: w_lap = (w_w <<< 1) + (w_s <<< 1) - (w_c <<< 2);
            CMD_BOT_LEFT:  w_lap = (w_e <<< 1) + (w_n <<< 1) - (w_c <<< 2);
            CMD_BOT_RIGHT: w_lap = (w_w <<< 1) + (w_n <<< 1) - (w_c <<< 2);
            default:       w_lap = w_w + w_e + w_n + w_s - (w_c <<< 2);
        endcase
    end

    // ---- pipeline registers
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic ld1, ld2, ld3, ld4, ld5, ld6;
    logic r1_int, r2_int, r3_int, r4_int, r5_int, r6_int;
    logic r1_k2, r2_k2, r5_neg, r6_neg;
    logic signed [LW-1:0]   r1_lap;
    logic signed [BW-1:0]   r1_base, r2_base, r3_base;
    logic signed [PW-1:0]   r1_pp;
    logic [CW-1:0]          r1_c, r2_c;
    logic signed [LCW-1:0]  r2_lc;
    logic signed [PCW-1:0]  r2_pc;
    logic [CIW-1:0]         r2_ci;
    logic signed [NW-1:0]   r3_lcc, r3_pl, r4_acc;
    logic [LSW-1:0]         r3_loss;
    logic [DEN_W-1:0]       r4_den;
    logic [XW-1:0]          r5_mag;
    logic [DIV_W-1:0]       r5_d2, r6_d2;
    logic signed [PHW-1:0]  r5_phi;
    logic [PLOW-1:0]        r5_plo;
    logic [DIV_W-1:0]       r6_rem;
    logic [QW-1:0]          r6_lo;
    logic signed [RW-1:0]   r6_ires;

    assign ld6 = !r6_v || i_ready;
    assign ld5 = !r5_v || ld6;
    assign ld4 = !r4_v || ld5;
    assign ld3 = !r3_v || ld4;
    assign ld2 = !r2_v || ld3;
    assign ld1 = !r1_v || ld2;
    assign i_cell.ready = ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0;
            r4_v <= 1'b0; r5_v <= 1'b0; r6_v <= 1'b0;
        end else begin
            if (ld1) r1_v <= i_cell.valid;
            if (ld2) r2_v <= r1_v;
            if (ld3) r3_v <= r2_v;
            if (ld4) r4_v <= r3_v;
            if (ld5) r5_v <= r4_v;
            if (ld6) r6_v <= r5_v;
        end
    end

    // stage 3..6 combinational terms
    logic signed [LCCF-1:0] w_lcc_full;
    logic signed [PLF-1:0]  w_pl_full;
    logic signed [NW-1:0]   w_pl, w_base_sh;
    logic signed [XW-1:0]   w_x;
    logic [DIV_W-1:0]       w_d2;
    logic [XW-1:0]          w_mag;
    logic signed [SW-1:0]   w_sum;

    assign w_lcc_full = r2_lc * $signed({1'b0, r2_c});
    assign w_pl_full  = r2_pc * $signed({1'b0, i_inv_wall});
    assign w_pl       = r2_k2 ? (NW'(w_pl_full) <<< 1) : NW'(w_pl_full);
    assign w_base_sh  = {{(NW-32-BW){r3_base[BW-1]}}, r3_base, 32'b0};
    assign w_x        = {r4_acc, 1'b0} + XW'(r4_den);
    assign w_d2       = {r4_den, 1'b0};
    // floor division of a negative dividend: magnitude (-x + d2 - 1)
    assign w_mag      = w_x[XW-1] ? (XW'(w_d2) + ~w_x) : w_x;
    assign w_sum      = (SW'(r5_phi) <<< 32)
                        + SW'(r5_plo) + (SW'(1) << (ROUND_SHIFT - 1));

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r1_lap  <= w_lap;
            r1_base <= w_base;
            r1_pp   <= i_cell.prev_pressure;
            r1_c    <= i_cell.courant;
            r1_int  <= w_int;
            r1_k2   <= w_k2;
        end
        if (ld2) begin
            r2_lc   <= r1_lap * $signed({1'b0, r1_c});
            r2_pc   <= r1_pp * $signed({1'b0, r1_c});
            r2_ci   <= r1_c * i_inv_wall;
            r2_c    <= r1_c;
            r2_base <= r1_base;
            r2_int  <= r1_int;
            r2_k2   <= r1_k2;
        end
        if (ld3) begin
            r3_lcc  <= w_lcc_full[NW-1:0];
            r3_pl   <= w_pl;
            r3_loss <= r2_k2 ? {r2_ci, 1'b0} : {1'b0, r2_ci};
            r3_base <= r2_base;
            r3_int  <= r2_int;
        end
        if (ld4) begin
            r4_acc  <= r3_lcc + w_base_sh + (r3_int ? NW'(0) : r3_pl);
            r4_den  <= (DEN_W'(1) << DEN_FRAC) + DEN_W'(r3_loss);
            r4_int  <= r3_int;
        end
        if (ld5) begin
            r5_mag  <= w_mag;
            r5_neg  <= w_x[XW-1];
            r5_d2   <= w_d2;
            r5_plo  <= r4_acc[31:0] * i_gain;
            r5_phi  <= $signed(r4_acc[NW-1:32]) * $signed({1'b0, i_gain});
            r5_int  <= r4_int;
        end
        if (ld6) begin
            r6_rem  <= DIV_W'(r5_mag[XW-1:QW]);
            r6_lo   <= r5_mag[QW-1:0];
            r6_d2   <= r5_d2;
            r6_ires <= w_sum[ROUND_SHIFT+RW-1:ROUND_SHIFT];
            r6_neg  <= r5_neg;
            r6_int  <= r5_int;
        end
    end

    assign o_ctl  = '{valid: r6_v, is_int: r6_int, neg: r6_neg};
    assign o_rem  = r6_rem;
    assign o_lo   = r6_lo;
    assign o_d2   = r6_d2;
    assign o_ires = r6_ires;
endmodule

FILE: sv/fdtd_div_stage.sv
// fdtd_div_stage: one stage of the pipelined restoring divider, a few
// quotient bits per stage. Depends on fdtd_pkg.
module fdtd_div_stage import fdtd_pkg::*; #(
    parameter int PW    = PRESSURE_WIDTH_DEF,
    parameter int NSTEP = DIV_STEPS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_pipe_ctl                     i_ctl,
    output logic                          o_ready,
    input  logic [DIV_W-1:0]              i_rem,
    input  logic [PW+QUO_XTRA-1:0]        i_lo,
    input  logic [DIV_W-1:0]              i_d2,
    input  logic signed [PW+RES_XTRA-1:0] i_ires,
    input  logic                          i_ready,
    output t_pipe_ctl                     o_ctl,
    output logic [DIV_W-1:0]              o_rem,
    output logic [PW+QUO_XTRA-1:0]        o_lo,
    output logic [DIV_W-1:0]              o_d2,
    output logic signed [PW+RES_XTRA-1:0] o_ires
);
    localparam int QW = PW + QUO_XTRA;
    localparam int RW = PW + RES_XTRA;

    logic [DIV_W-1:0] w_rem;
    logic [QW-1:0]    w_lo;
    logic             ld;
    t_pipe_ctl        r_ctl;
    logic [DIV_W-1:0] r_rem, r_d2;
    logic [QW-1:0]    r_lo;
    logic signed [RW-1:0] r_ires;

    // dividend bits shift out of lo's top while quotient bits fill its bottom
    always_comb begin
        logic [DIV_W:0] t;
        w_rem = i_rem;
        w_lo  = i_lo;
        for (int s = 0; s < NSTEP; s++) begin
            t    = {w_rem, w_lo[QW-1]};
            w_lo = {w_lo[QW-2:0], 1'b0};
            if (t >= {1'b0, i_d2}) begin
                t       = t - {1'b0, i_d2};
                w_lo[0] = 1'b1;
            end
            w_rem = t[DIV_W-1:0];
        end
    end

    assign ld      = !r_ctl.valid || i_ready;
    assign o_ready = ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (ld) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_rem  <= w_rem;
            r_lo   <= w_lo;
            r_d2   <= i_d2;
            r_ires <= i_ires;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_lo   = r_lo;
    assign o_d2   = r_d2;
    assign o_ires = r_ires;
endmodule

FILE: sv/fdtd_sat_out.sv
// fdtd_sat_out: result select, sign restore, saturation and output register.
// Depends on fdtd_pkg and fdtd_if.
module fdtd_sat_out import fdtd_pkg::*; #(
    parameter int PW = PRESSURE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_pipe_ctl                     i_ctl,
    input  logic [PW+QUO_XTRA-1:0]        i_quo,
    input  logic signed [PW+RES_XTRA-1:0] i_ires,
    output logic                          o_ready,
    fdtd_out_if.source                    o_cell
);
    localparam int RW = PW + RES_XTRA;
    localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};

    logic signed [RW-1:0] w_q, w_res;
    logic [RW-PW:0]       w_top;
    logic                 w_ovf;
    logic signed [PW-1:0] w_val;
    logic                 ld;
    logic                 r_v, r_sat;
    logic signed [PW-1:0] r_val;

    assign w_q   = {1'b0, i_quo};
    assign w_res = i_ctl.is_int ? i_ires : (i_ctl.neg ? -w_q : w_q);
    assign w_top = w_res[RW-1:PW-1];
    assign w_ovf = !((&w_top) || !(|w_top));
    assign w_val = w_ovf ? (w_res[RW-1] ? PMIN : PMAX) : w_res[PW-1:0];

    assign ld      = !r_v || o_cell.ready;
    assign o_ready = ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (ld) begin
            r_v <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_val <= w_val;
            r_sat <= w_ovf;
        end
    end

    assign o_cell.valid         = r_v;
    assign o_cell.next_pressure = r_val;
    assign o_cell.saturated     = r_sat;
endmodule

FILE: sv/fdtd_wave_cell_update.sv
// fdtd_wave_cell_update: top level of the 2D acoustic FDTD cell update.
// Depends on fdtd_pkg, fdtd_if, fdtd_stencil, fdtd_div_stage, fdtd_sat_out.
//
// Usage:
//  - i_cell (valid/ready) carries one cell request: position class, current,
//    previous and four neighbour pressures, Courant number.
//  - o_cell (valid/ready) returns the next pressure and a saturation flag,
//    one result per request, in request order.
//  - APB port: inv_wall_ratio at 0x0, damping_gain at 0x4; write only while
//    the pipeline is empty. pready is tied high.
//  - Throughput: one request per cycle while o_cell.ready stays high. The
//    pipe is made of the six front stages, the divider chain at four
//    quotient bits per stage, and the output register.
//  - Every request walks the full pipe; interior cells carry their rounded
//    result through the divider stages untouched.
//  - Reset (synchronous, active low) empties all stages and reloads the
//    register defaults.
//  - A stalled receiver holds the output register; stages behind it keep
//    filling bubbles, and i_cell.ready drops only once every stage is full.
module fdtd_wave_cell_update import fdtd_pkg::*; #(
    parameter int PRESSURE_WIDTH = PRESSURE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fdtd_in_if.sink               i_cell,
    fdtd_out_if.source            o_cell,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    localparam int PW = PRESSURE_WIDTH;
    localparam int QW = PW + QUO_XTRA;
    localparam int RW = PW + RES_XTRA;
    localparam int NS = (QW + DIV_STEPS - 1) / DIV_STEPS;

    // ---- configuration registers
    logic                  w_wr;
    logic [INV_WALL_W-1:0] r_inv_wall;
    logic [GAIN_W-1:0]     r_gain;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_wall <= INV_WALL_RST;
            r_gain     <= GAIN_RST;
        end else if (w_wr) begin
            if (paddr[2] == REG_INV_WALL) r_inv_wall <= pwdata[INV_WALL_W-1:0];
            if (paddr[2] == REG_GAIN)     r_gain     <= pwdata[GAIN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_GAIN) ? APB_DATA_W'(r_gain)
                                           : APB_DATA_W'(r_inv_wall);

    // ---- pipeline: front stages, divider chain, output
    t_pipe_ctl            w_ctl  [NS+1];
    logic                 w_rdy  [NS+1];
    logic [DIV_W-1:0]     w_rem  [NS+1];
    logic [QW-1:0]        w_lo   [NS+1];
    logic [DIV_W-1:0]     w_d2   [NS+1];
    logic signed [RW-1:0] w_ires [NS+1];

    fdtd_stencil #(.PW(PW)) u_stencil (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cell     (i_cell),
        .i_inv_wall (r_inv_wall),
        .i_gain     (r_gain),
        .i_ready    (w_rdy[0]),
        .o_ctl      (w_ctl[0]),
        .o_rem      (w_rem[0]),
        .o_lo       (w_lo[0]),
        .o_d2       (w_d2[0]),
        .o_ires     (w_ires[0])
    );

    for (genvar s = 0; s < NS; s++) begin : g_div
        // the last stage takes whatever quotient bits remain
        localparam int LEFT  = QW - s * DIV_STEPS;
        localparam int STEPS = (LEFT < DIV_STEPS) ? LEFT : DIV_STEPS;
        fdtd_div_stage #(.PW(PW), .NSTEP(STEPS)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[s]),
            .o_ready (w_rdy[s]),
            .i_rem   (w_rem[s]),
            .i_lo    (w_lo[s]),
            .i_d2    (w_d2[s]),
            .i_ires  (w_ires[s]),
            .i_ready (w_rdy[s+1]),
            .o_ctl   (w_ctl[s+1]),
            .o_rem   (w_rem[s+1]),
            .o_lo    (w_lo[s+1]),
            .o_d2    (w_d2[s+1]),
            .o_ires  (w_ires[s+1])
        );
    end

    fdtd_sat_out #(.PW(PW)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl[NS]),
        .i_quo   (w_lo[NS]),
        .i_ires  (w_ires[NS]),
        .o_ready (w_rdy[NS]),
        .o_cell  (o_cell)
    );

    // ---- assertions
    // input backpressure only when the output holds a result and the sink stalls
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cell.ready |-> (o_cell.valid && !o_cell.ready))
        else $error("input stalled while pipeline has room");

    // a flagged result sits at one of the range limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cell.valid && o_cell.saturated) |->
            ((o_cell.next_pressure == {1'b0, {(PW-1){1'b1}}}) ||
             (o_cell.next_pressure == {1'b1, {(PW-1){1'b0}}})))
        else $error("saturated result not at range limit");

    // reset restores register defaults
    a_cfg_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_inv_wall == INV_WALL_RST && r_gain == GAIN_RST))
        else $error("config registers not at reset values");
endmodule

FILE: tb/tb_fdtd_wave_cell_update.sv
// Self-checking testbench for fdtd_wave_cell_update: random and directed cell
// requests, APB register settings, a scoreboard class with a bit-exact predictor.
// Depends on fdtd_pkg, fdtd_if and the RTL of the cell update.
module tb_fdtd_wave_cell_update;
    import fdtd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW       = 32;
    localparam int WDOG_MAX = 20000;
    localparam int LATENCY  = 17;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic signed [PW-1:0] cur, prev, west, east, north, south;
        logic [COURANT_W-1:0] courant;
    } t_cell_req;

    typedef struct packed {
        logic signed [PW-1:0] next_p;
        logic                 sat;
    } t_cell_res;

    // Expected-result store plus the cell-update predictor.
    class t_cell_scoreboard;
        t_cell_res pending_q[$];
        logic [INV_WALL_W-1:0] inv_wall;
        logic [GAIN_W-1:0]     gain;
        int errors;
        int n_checked;
        int n_sat;

        function new();
            inv_wall  = INV_WALL_RST;
            gain      = GAIN_RST;
            errors    = 0;
            n_checked = 0;
            n_sat     = 0;
        endfunction

        // Floor division for a positive divisor.
        function automatic logic signed [159:0] floor_div(logic signed [159:0] n,
                                                          logic signed [159:0] d);
            logic signed [159:0] q;
            q = n / d;
            if ((q * d) != n && n < 0) q = q - 1;
            return q;
        endfunction

        function automatic t_cell_res predict_cell(t_cell_req r);
            logic signed [159:0] pc, pp, pw, pe, pn, ps, lap, csq, acc, loss, den, q;
            logic signed [159:0] maxv, minv;
            logic [1:0] k;
            t_cell_res res;
            pc = r.cur; pp = r.prev; pw = r.west; pe = r.east; pn = r.north; ps = r.south;
            csq = r.courant * r.courant;
            maxv = (160'sd1 <<< (PW - 1)) - 1;
            minv = -(160'sd1 <<< (PW - 1));
            if (r.cmd == CMD_INTERIOR || r.cmd > CMD_BOT_RIGHT) begin
                lap = pw + pe + pn + ps - 4 * pc;
                acc = (lap * csq + ((2 * pc - pp) <<< 32)) * gain;
                q = (acc + (160'sd1 <<< 47)) >>> 48;
            end else begin
                k = (r.cmd >= CMD_TOP_LEFT) ? 2'd2 : 2'd1;
                case (r.cmd)
                    CMD_LEFT:      lap = 2 * pe + pn + ps - 4 * pc;
                    CMD_RIGHT:     lap = 2 * pw + pn + ps - 4 * pc;
                    CMD_TOP:       lap = 2 * ps + pw + pe - 4 * pc;
                    CMD_BOTTOM:    lap = 2 * pn + pw + pe - 4 * pc;
                    CMD_TOP_LEFT:  lap = 2 * pe + 2 * ps - 4 * pc;
                    CMD_TOP_RIGHT: lap = 2 * pw + 2 * ps - 4 * pc;
                    CMD_BOT_LEFT:  lap = 2 * pe + 2 * pn - 4 * pc;
                    default:       lap = 2 * pw + 2 * pn - 4 * pc;
                endcase
                loss = k * r.courant * inv_wall;
                den = (160'sd1 <<< 32) + loss;
                acc = lap * csq + pp * loss + ((2 * pc - pp) <<< 32);
                // round half up: floor((2*num + den) / (2*den))
                q = floor_div(2 * acc + den, 2 * den);
            end
            res.sat = (q > maxv) || (q < minv);
            res.next_p = (q > maxv) ? maxv[PW-1:0] : (q < minv) ? minv[PW-1:0] : q[PW-1:0];
            return res;
        endfunction

        function void note_request(t_cell_req r);
            pending_q.insert(pending_q.size(), predict_cell(r));
        endfunction

        function void check_result(t_cell_res got);
            t_cell_res exp_r;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result next=%0d sat=%0b", $time, got.next_p, got.sat);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            n_checked++;
            if (got.sat) n_sat++;
            if (got.next_p !== exp_r.next_p) begin
                $display("%0t: next_pressure expected %0d actual %0d",
                         $time, exp_r.next_p, got.next_p);
                errors++;
            end
            if (got.sat !== exp_r.sat) begin
                $display("%0t: saturated expected %0b actual %0b", $time, exp_r.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    fdtd_in_if  #(.PW(PW)) cell_in ();
    fdtd_out_if #(.PW(PW)) cell_out ();

    fdtd_wave_cell_update #(.PRESSURE_WIDTH(PW)) u_dut (
        .i_clk, .i_rst_n, .i_cell(cell_in), .o_cell(cell_out),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #5 i_clk = ~i_clk;

    t_cell_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  stim_done = 1'b0;
    bit  test_done = 1'b0;
    int  n_sent = 0;
    int  n_cfg = 0;

    initial begin
        cell_in.valid = 1'b0;
        cell_in.cmd = '0;
        cell_in.cur_pressure = '0;
        cell_in.prev_pressure = '0;
        cell_in.west_pressure = '0;
        cell_in.east_pressure = '0;
        cell_in.north_pressure = '0;
        cell_in.south_pressure = '0;
        cell_in.courant = '0;
        cell_out.ready = 1'b0;
    end

    // Watchdog: cycles with no accepted request on either side.
    always @(posedge i_clk) begin
        if ((cell_in.valid && cell_in.ready) || (cell_out.valid && cell_out.ready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX && !test_done) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, sb.pending_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stalls, check on accept.
    initial begin : result_sink
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                cell_out.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            cell_out.ready <= 1'b1;
            @(posedge i_clk iff cell_out.valid);
            sb.check_result({cell_out.next_pressure, cell_out.saturated});
        end
    end

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk iff pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        n_cfg++;
    endtask

    task automatic set_regs(input logic [INV_WALL_W-1:0] iw, input logic [GAIN_W-1:0] g);
        // pipeline must be drained; boundary and interior both yield a result
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
        apb_write(3'(REG_INV_WALL) << 2, 32'(iw));
        apb_write(3'(REG_GAIN) << 2, 32'(g));
        sb.inv_wall = iw;
        sb.gain = g;
    endtask

    task automatic send_cell(input t_cell_req r, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            cell_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cell_in.valid          <= 1'b1;
        cell_in.cmd            <= r.cmd;
        cell_in.cur_pressure   <= r.cur;
        cell_in.prev_pressure  <= r.prev;
        cell_in.west_pressure  <= r.west;
        cell_in.east_pressure  <= r.east;
        cell_in.north_pressure <= r.north;
        cell_in.south_pressure <= r.south;
        cell_in.courant        <= r.courant;
        @(posedge i_clk iff cell_in.ready);
        sb.note_request(r);
        n_sent++;
    endtask

    task automatic idle_input();
        cell_in.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pressure values: full-range noise, physical magnitudes, or extremes.
    function automatic logic signed [PW-1:0] rand_pressure();
        case ($urandom_range(0, 5))
            0:       return PW'($urandom);
            1:       return ($urandom_range(0, 1)) ? {1'b0, {(PW-1){1'b1}}} : {1'b1, {(PW-1){1'b0}}};
            default: return PW'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
        endcase
    endfunction

    function automatic t_cell_req rand_cell();
        t_cell_req r;
        r.cmd = ($urandom_range(0, 15) == 0) ? CMD_W'($urandom_range(9, 15))
                                              : CMD_W'($urandom_range(0, 8));
        r.cur = rand_pressure(); r.prev = rand_pressure();
        r.west = rand_pressure(); r.east = rand_pressure();
        r.north = rand_pressure(); r.south = rand_pressure();
        case ($urandom_range(0, 4))
            0:       r.courant = COURANT_W'($urandom_range(0, 131071));
            1:       r.courant = ($urandom_range(0, 1)) ? 17'd65536 : 17'd0;
            default: r.courant = COURANT_W'($urandom_range(30000, 46341));
        endcase
        return r;
    endfunction

    initial begin : stimulus
        t_cell_req r;
        logic signed [PW-1:0] pmax, pmin;
        bit burst;
        pmax = {1'b0, {(PW-1){1'b1}}};
        pmin = {1'b1, {(PW-1){1'b0}}};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every class incl. unused codes at defaults, with extremes.
        for (int c = 0; c < 16; c++) begin
            r = '{cmd: CMD_W'(c), cur: 32'sh0100_0000, prev: 32'sh0080_0000,
                  west: 32'sh0200_0000, east: -32'sh0100_0000, north: 32'sh0040_0000,
                  south: 32'sh0010_0000, courant: 17'd46341};
            send_cell(r, c[0]);
        end
        send_cell('{CMD_INTERIOR, pmax, pmin, pmax, pmax, pmax, pmax, 17'h1ffff}, 1'b0);
        send_cell('{CMD_INTERIOR, pmin, pmax, pmin, pmin, pmin, pmin, 17'h1ffff}, 1'b1);
        send_cell('{CMD_BOT_RIGHT, pmax, pmin, pmax, pmin, pmax, pmin, 17'd65536}, 1'b0);
        send_cell('{CMD_TOP_LEFT, pmin, pmax, pmin, pmax, pmin, pmax, 17'd0}, 1'b1);
        send_cell('{CMD_LEFT, '0, '0, '0, '0, '0, '0, 17'd0}, 1'b0);
        idle_input();
        // rigid wall and zero gain, then maximum values
        set_regs('0, '0);
        for (int c = 0; c < 9; c++) send_cell(rand_cell(), 1'b0);
        idle_input();
        set_regs(18'h3ffff, 17'h1ffff);

        // Random phases across register settings.
        for (int ph = 0; ph < 6; ph++) begin
            for (int i = 0; i < 250; i++) begin
                burst = ($urandom_range(0, 3) == 0) || (i >= 100 && i < 140);
                r = rand_cell();
                if (i % 97 == 0) r.cmd = CMD_W'($urandom_range(0, 15));
                send_cell(r, burst);
            end
            idle_input();
            case (ph)
                0:       set_regs(INV_WALL_RST, GAIN_RST);
                1:       set_regs(18'd0, 17'd65536);
                2:       set_regs(18'h3ffff, 17'd0);
                default: set_regs(INV_WALL_W'($urandom), GAIN_W'($urandom_range(0, 65536)));
            endcase
        end
        stim_done = 1'b1;
    end

    initial begin : finisher
        wait (stim_done);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY * 2) @(posedge i_clk);
        test_done = 1'b1;
        $display("Sent %0d cell requests, checked %0d results (%0d saturated), %0d reg writes",
                 n_sent, sb.n_checked, sb.n_sat, n_cfg);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
